FILE: rtl/assembler_source_byte_normalizer_top_macros.svh
// Assertion macros shared by the source byte normalizer RTL
`ifndef ASSEMBLER_SOURCE_BYTE_NORMALIZER_TOP_MACROS_SVH
`define ASSEMBLER_SOURCE_BYTE_NORMALIZER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASBN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ASBN_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/asbn_pkg.sv
// Package: types and constants of the source byte normalizer
`default_nettype none

package asbn_pkg;

	localparam int LINE_BITS_DEF   = 24;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int SLOTS           = 3;

	localparam logic [7:0] BYTE_NUL    = 8'd0;
	localparam logic [7:0] BYTE_TAB    = 8'd9;
	localparam logic [7:0] BYTE_LF     = 8'd10;
	localparam logic [7:0] BYTE_CR     = 8'd13;
	localparam logic [7:0] BYTE_SPACE  = 8'd32;
	localparam logic [7:0] CHAR_HASH   = 8'h23;
	localparam logic [7:0] CHAR_SLASH  = 8'h2f;
	localparam logic [7:0] CHAR_COLON  = 8'h3a;
	localparam logic [7:0] CHAR_SEMI   = 8'h3b;
	localparam logic [7:0] CHAR_RBRACE = 8'h7d;

	typedef logic [23:0] line_count_t;

	typedef enum logic [2:0] {
		KIND_CHAR = 3'd0,
		KIND_EOS  = 3'd1,
		KIND_SOL  = 3'd2,
		KIND_EOB  = 3'd3,
		KIND_EOF  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic        ill;
		line_count_t line;
	} slot_t;

	// all results of one accepted input, oldest in slot 0
	typedef struct packed {
		slot_t [SLOTS-1:0] slot;
		logic  [1:0]       num;
	} bundle_t;

endpackage

`default_nettype wire

FILE: rtl/assembler_source_byte_normalizer_top.sv
// Top level of the assembler source byte normalizer
//
// Input channel: push/full queue. A source byte or an end-of-file marker
// (is_end) is taken on a rising edge with push high and full low.
// Result channel: empty/pop queue. The oldest result is on kind, out_char,
// illegal, line_count and last while empty is low; pop takes it.
// Each input gives zero to three results; last marks the final one.
// The results of a taken input are written to the queue as one bundle.
// Throughput: one input per cycle while full is low; an input with n results
// needs n pops on the result side, and the bundle queue (QUEUE_DEPTH inputs)
// absorbs such bursts before full rises.
// Inputs that give no result (blanks in a run, comment text) never occupy
// the queue.
// Reset clears the scan state to start of file, the line count to one and
// empties the queue. If the receiver stops popping, results pile up in the
// queue and full rises once it holds QUEUE_DEPTH bundles; nothing is lost.
`default_nettype none

module assembler_source_byte_normalizer_top #(
	parameter int LINE_BITS   = asbn_pkg::LINE_BITS_DEF,
	parameter int QUEUE_DEPTH = asbn_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [7:0]  src_byte,
	input  wire logic        is_end,
	output      logic        empty,
	input  wire logic        pop,
	output      logic [2:0]  kind,
	output      logic [7:0]  out_char,
	output      logic        illegal,
	output      logic [23:0] line_count,
	output      logic        last
);

	logic              q_push, q_pop, q_empty;
	asbn_pkg::bundle_t q_wdata, q_head;

	asbn_front #(
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.q_full  (full),
		.src_byte(src_byte),
		.is_end  (is_end),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	asbn_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_data(q_wdata),
		.rd     (q_pop),
		.full   (full),
		.empty  (q_empty),
		.head   (q_head)
	);

	asbn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.out_char  (out_char),
		.illegal   (illegal),
		.line_count(line_count),
		.last      (last)
	);

endmodule

`default_nettype wire

FILE: rtl/asbn_front.sv
// Front end: scan state, line counter and per-byte result bundles
`default_nettype none

module asbn_front #(
	parameter int LINE_BITS = asbn_pkg::LINE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic              q_full,
	input  wire logic [7:0]        src_byte,
	input  wire logic              is_end,
	output      logic              q_push,
	output      asbn_pkg::bundle_t q_data
);

	`include "assembler_source_byte_normalizer_top_macros.svh"

	typedef enum logic [5:0] {
		M_SOF     = 6'b000001,
		M_NORMAL  = 6'b000010,
		M_BLANKS  = 6'b000100,
		M_COMMENT = 6'b001000,
		M_CRSEEN  = 6'b010000,
		M_SLASH   = 6'b100000
	} mode_t;

	mode_t                mode_q, nxt_mode, cls_mode;
	logic [LINE_BITS-1:0] cnt_q, nxt_cnt, cnt_inc;
	asbn_pkg::line_count_t line_cur, line_inc;
	asbn_pkg::slot_t      cls_a, cls_b, a, b, slash_s, eos_s, eof_s;
	logic                 cls_av, cls_bv, pv, av, bv, use_cls, blank, accept;

	assign accept   = push && !q_full;
	assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	assign line_cur = asbn_pkg::line_count_t'(cnt_q);
	assign line_inc = asbn_pkg::line_count_t'(cnt_inc);
	assign blank    = (src_byte == asbn_pkg::BYTE_TAB) || (src_byte == asbn_pkg::BYTE_SPACE);

	assign slash_s = '{asbn_pkg::KIND_CHAR, asbn_pkg::CHAR_SLASH, 1'b0, line_cur};
	assign eos_s   = '{asbn_pkg::KIND_EOS, 8'd0, 1'b0, line_cur};
	assign eof_s   = '{asbn_pkg::KIND_EOF, 8'd0, 1'b0, line_cur};

	always_comb begin
		cls_av   = 1'b1;
		cls_a    = '{asbn_pkg::KIND_CHAR, src_byte, 1'b0, line_cur};
		cls_bv   = 1'b0;
		cls_b    = eos_s;
		cls_mode = M_NORMAL;
		if (src_byte == asbn_pkg::BYTE_NUL) begin
			cls_a.ill = 1'b1;
		end else if (blank) begin
			cls_a.ch = asbn_pkg::BYTE_SPACE;
			cls_mode = M_BLANKS;
		end else if (src_byte == asbn_pkg::BYTE_LF || src_byte == asbn_pkg::BYTE_CR) begin
			cls_a  = eos_s;
			cls_bv = 1'b1;
			cls_b  = '{asbn_pkg::KIND_SOL, 8'd0, 1'b0, line_inc};
			if (src_byte == asbn_pkg::BYTE_CR)
				cls_mode = M_CRSEEN;
		end else if (src_byte == asbn_pkg::CHAR_RBRACE) begin
			cls_a  = eos_s;
			cls_bv = 1'b1;
			cls_b  = '{asbn_pkg::KIND_EOB, 8'd0, 1'b0, line_cur};
		end else if (src_byte == asbn_pkg::CHAR_SLASH) begin
			cls_av   = 1'b0;
			cls_mode = M_SLASH;
		end else if (src_byte == asbn_pkg::CHAR_SEMI) begin
			cls_a    = eos_s;
			cls_mode = M_COMMENT;
		end else if (src_byte == asbn_pkg::CHAR_COLON) begin
			cls_a = eos_s;
		end
	end

	always_comb begin
		pv       = 1'b0;
		av       = 1'b0;
		bv       = 1'b0;
		a        = eos_s;
		b        = eof_s;
		use_cls  = 1'b0;
		nxt_mode = mode_q;
		nxt_cnt  = cnt_q;
		if (is_end) begin
			pv       = (mode_q == M_SLASH);
			av       = 1'b1;
			bv       = 1'b1;
			nxt_mode = M_SOF;
			nxt_cnt  = LINE_BITS'(1);
		end else begin
			case (mode_q)
				M_SOF: begin
					if (src_byte == asbn_pkg::CHAR_HASH) begin
						av       = 1'b1;
						nxt_mode = M_COMMENT;
					end else begin
						use_cls = 1'b1;
					end
				end
				M_BLANKS: use_cls = !blank;
				M_COMMENT: begin
					use_cls = (src_byte == asbn_pkg::BYTE_LF) ||
					          (src_byte == asbn_pkg::BYTE_CR);
				end
				M_CRSEEN: begin
					if (src_byte == asbn_pkg::BYTE_LF)
						nxt_mode = M_NORMAL;
					else
						use_cls = 1'b1;
				end
				M_SLASH: begin
					if (src_byte == asbn_pkg::CHAR_SLASH) begin
						av       = 1'b1;
						nxt_mode = M_COMMENT;
					end else begin
						pv      = 1'b1;
						use_cls = 1'b1;
					end
				end
				default: use_cls = 1'b1;
			endcase
			if (use_cls) begin
				av       = cls_av;
				a        = cls_a;
				bv       = cls_bv;
				b        = cls_b;
				nxt_mode = cls_mode;
				if (cls_bv && cls_b.kind == asbn_pkg::KIND_SOL)
					nxt_cnt = cnt_inc;
			end
		end
	end

	always_comb begin
		q_data.slot[0] = pv ? slash_s : a;
		q_data.slot[1] = pv ? a : b;
		q_data.slot[2] = b;
		q_data.num     = {1'b0, pv} + {1'b0, av} + {1'b0, bv};
	end

	assign q_push = accept && (q_data.num != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SOF;
			cnt_q  <= LINE_BITS'(1);
		end else if (accept) begin
			mode_q <= nxt_mode;
			cnt_q  <= nxt_cnt;
		end
	end

	`ASBN_ASSERT_IMP(a_line_nonzero, 1'b1, cnt_q != '0, "line counter reached zero")
	`ASBN_ASSERT_NXT(a_end_restarts, accept && is_end, mode_q == M_SOF && cnt_q == LINE_BITS'(1), "end of file did not restart the scan")

endmodule

`default_nettype wire

FILE: rtl/asbn_queue.sv
// Short bundle queue between front end and result sequencer
`default_nettype none

module asbn_queue #(
	parameter int DEPTH = asbn_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire asbn_pkg::bundle_t wr_data,
	input  wire logic              rd,
	output      logic              full,
	output      logic              empty,
	output      asbn_pkg::bundle_t head
);

	`include "assembler_source_byte_normalizer_top_macros.svh"

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	asbn_pkg::bundle_t mem [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_wr, do_rd;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	`ASBN_ASSERT_IMP(a_no_write_full, wr, !full, "write into a full queue")
	`ASBN_ASSERT_NXT(a_write_fills, do_wr && !do_rd, !empty, "queue empty after a write")

endmodule

`default_nettype wire

FILE: rtl/asbn_back.sv
// Result sequencer: hands out the slots of the head bundle one by one
`default_nettype none

module asbn_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire asbn_pkg::bundle_t q_head,
	output      logic              q_pop,
	input  wire logic              pop,
	output      logic              empty,
	output      logic [2:0]        kind,
	output      logic [7:0]        out_char,
	output      logic              illegal,
	output      logic [23:0]       line_count,
	output      logic              last
);

	`include "assembler_source_byte_normalizer_top_macros.svh"

	logic [1:0]      slot_q;
	asbn_pkg::slot_t cur;
	logic            take;

	assign cur        = q_head.slot[slot_q];
	assign empty      = q_empty;
	assign kind       = cur.kind;
	assign out_char   = cur.ch;
	assign illegal    = cur.ill;
	assign line_count = cur.line;
	assign last       = (slot_q == q_head.num - 2'd1);
	assign take       = pop && !q_empty;
	assign q_pop      = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (take) begin
			slot_q <= last ? 2'd0 : slot_q + 2'd1;
		end
	end

	`ASBN_ASSERT_IMP(a_slot_in_bundle, !q_empty, slot_q < q_head.num, "slot index beyond bundle")
	`ASBN_ASSERT_IMP(a_idle_slot_zero, q_empty, slot_q == 2'd0, "slot index left over while idle")

endmodule

`default_nettype wire

FILE: bench/asbn_stream_checker.sv
// Checker for the source byte normalizer: tracks accepted bytes, predicts tokens, compares them
`default_nettype none

module asbn_stream_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic [7:0]  src_byte,
	input  wire logic        is_end,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  out_char,
	input  wire logic        illegal,
	input  wire logic [23:0] line_count,
	input  wire logic        last,
	output int               errors,
	output int               waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		SCAN_SOF,
		SCAN_NORMAL,
		SCAN_BLANKS,
		SCAN_COMMENT,
		SCAN_CR_SEEN,
		SCAN_SLASH
	} scan_mode_t;

	typedef struct packed {
		asbn_pkg::kind_t       kind;
		logic [7:0]            ch;
		logic                  ill;
		asbn_pkg::line_count_t line;
		logic                  last;
	} token_t;

	scan_mode_t            mode;
	asbn_pkg::line_count_t line_no;
	token_t                staged[asbn_pkg::SLOTS];
	int                    n_staged;
	token_t                expected_tokens[$];

	task automatic stage(input asbn_pkg::kind_t k, input logic [7:0] c, input logic ill);
		if (n_staged < asbn_pkg::SLOTS) begin
			if (k == asbn_pkg::KIND_SOL && line_no != {24{1'b1}})
				line_no = line_no + 1'b1;
			staged[n_staged] = '{k, (k == asbn_pkg::KIND_CHAR) ? c : 8'd0, ill, line_no, 1'b0};
			n_staged++;
		end
	endtask

	task automatic classify(input logic [7:0] c);
		mode = SCAN_NORMAL;
		case (c)
			asbn_pkg::BYTE_NUL: stage(asbn_pkg::KIND_CHAR, asbn_pkg::BYTE_NUL, 1'b1);
			asbn_pkg::BYTE_TAB, asbn_pkg::BYTE_SPACE: begin
				stage(asbn_pkg::KIND_CHAR, asbn_pkg::BYTE_SPACE, 1'b0);
				mode = SCAN_BLANKS;
			end
			asbn_pkg::BYTE_LF: begin
				stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
				stage(asbn_pkg::KIND_SOL, 8'd0, 1'b0);
			end
			asbn_pkg::BYTE_CR: begin
				stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
				stage(asbn_pkg::KIND_SOL, 8'd0, 1'b0);
				mode = SCAN_CR_SEEN;
			end
			asbn_pkg::CHAR_RBRACE: begin
				stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
				stage(asbn_pkg::KIND_EOB, 8'd0, 1'b0);
			end
			asbn_pkg::CHAR_SLASH: mode = SCAN_SLASH;
			asbn_pkg::CHAR_SEMI: begin
				stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
				mode = SCAN_COMMENT;
			end
			asbn_pkg::CHAR_COLON: stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
			default: stage(asbn_pkg::KIND_CHAR, c, 1'b0);
		endcase
	endtask

	task automatic normalize(input logic [7:0] c, input logic at_end);
		n_staged = 0;
		if (at_end) begin
			if (mode == SCAN_SLASH)
				stage(asbn_pkg::KIND_CHAR, asbn_pkg::CHAR_SLASH, 1'b0);
			stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
			stage(asbn_pkg::KIND_EOF, 8'd0, 1'b0);
			mode = SCAN_SOF;
			line_no = 24'd1;
		end else begin
			case (mode)
				SCAN_SOF: begin
					if (c == asbn_pkg::CHAR_HASH) begin
						stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
						mode = SCAN_COMMENT;
					end else begin
						classify(c);
					end
				end
				SCAN_BLANKS: begin
					if (c != asbn_pkg::BYTE_TAB && c != asbn_pkg::BYTE_SPACE)
						classify(c);
				end
				SCAN_COMMENT: begin
					if (c == asbn_pkg::BYTE_LF || c == asbn_pkg::BYTE_CR)
						classify(c);
				end
				SCAN_CR_SEEN: begin
					if (c == asbn_pkg::BYTE_LF)
						mode = SCAN_NORMAL;
					else
						classify(c);
				end
				SCAN_SLASH: begin
					if (c == asbn_pkg::CHAR_SLASH) begin
						stage(asbn_pkg::KIND_EOS, 8'd0, 1'b0);
						mode = SCAN_COMMENT;
					end else begin
						stage(asbn_pkg::KIND_CHAR, asbn_pkg::CHAR_SLASH, 1'b0);
						classify(c);
					end
				end
				default: classify(c);
			endcase
		end
		if (n_staged > 0)
			staged[n_staged - 1].last = 1'b1;
		for (int i = 0; i < n_staged; i++)
			expected_tokens.push_back(staged[i]);
	endtask

	task automatic compare_field(input string name, input logic [23:0] want,
		input logic [23:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			mode = SCAN_SOF;
			line_no = 24'd1;
			expected_tokens.delete();
			errors = 0;
			waiting = 0;
		end else begin
			if (push && !full)
				normalize(src_byte, is_end);
			if (pop && !empty) begin
				if (expected_tokens.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, expected none, %s %0d %0h %0d",
						$time, "actual kind/char/line", kind, out_char, line_count);
				end else begin
					want = expected_tokens.pop_front();
					compare_field("kind", 24'(want.kind), 24'(kind));
					compare_field("out_char", 24'(want.ch), 24'(out_char));
					compare_field("illegal", 24'(want.ill), 24'(illegal));
					compare_field("line_count", want.line, line_count);
					compare_field("last", 24'(want.last), 24'(last));
				end
			end
			waiting = expected_tokens.size();
		end
	end

endmodule

`default_nettype wire

FILE: bench/assembler_source_byte_normalizer_top_tb.sv
// Testbench top: source text stimulus, bursty sender, stalling receiver and verdict
`default_nettype none

module assembler_source_byte_normalizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 110;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
	} src_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        push     = 1'b0;
	logic [7:0]  src_byte = 8'd0;
	logic        is_end   = 1'b0;
	logic        pop      = 1'b0;
	logic        full;
	logic        empty;
	logic [2:0]  kind;
	logic [7:0]  out_char;
	logic        illegal;
	logic [23:0] line_count;
	logic        last;

	int          errors;
	int          waiting;
	int          cycles;
	int          pop_left;
	int          pop_style;
	src_item_t   source_text[$];

	assembler_source_byte_normalizer_top uut (
		.clk, .arst_n, .push, .full, .src_byte, .is_end,
		.empty, .pop, .kind, .out_char, .illegal, .line_count, .last
	);

	asbn_stream_checker stream_check (
		.clk, .arst_n, .push, .full, .src_byte, .is_end,
		.empty, .pop, .kind, .out_char, .illegal, .line_count, .last,
		.errors, .waiting
	);

	always #5 clk = ~clk;

	// receiver: phases of steady popping, random popping, sparse popping and stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_left <= 0;
			pop_style <= 0;
		end else begin
			if (pop_left == 0) begin
				pop_left <= $urandom_range(1, 40);
				pop_style <= $urandom_range(0, 3);
			end else begin
				pop_left <= pop_left - 1;
			end
			case (pop_style)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= 1'b0;
			endcase
		end
	end

	task automatic add(input logic [7:0] b, input logic e);
		source_text.push_back('{b, e});
	endtask

	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 8'($urandom_range(0, 255));
		else if (r < 3)
			return 8'($urandom_range(48, 57));
		else
			return 8'($urandom_range(65, 90) + 32 * $urandom_range(0, 1));
	endfunction

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? asbn_pkg::BYTE_TAB : asbn_pkg::BYTE_SPACE;
	endfunction

	task automatic add_comment_text();
		logic [7:0] c;
		int n;
		n = $urandom_range(0, 6);
		repeat (n) begin
			c = 8'($urandom_range(0, 255));
			if (c == asbn_pkg::BYTE_LF || c == asbn_pkg::BYTE_CR)
				c = "x";
			add(c, 1'b0);
		end
	endtask

	task automatic add_eol();
		case ($urandom_range(0, 2))
			0: add(asbn_pkg::BYTE_LF, 1'b0);
			1: add(asbn_pkg::BYTE_CR, 1'b0);
			default: begin
				add(asbn_pkg::BYTE_CR, 1'b0);
				add(asbn_pkg::BYTE_LF, 1'b0);
			end
		endcase
	endtask

	task automatic add_line();
		int pieces;
		pieces = $urandom_range(1, 5);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 6)) add(word_char(), 1'b0);
				3, 4: begin
					add(blank_char(), 1'b0);
					repeat ($urandom_range(0, 3))
						add(blank_char(), 1'b0);
				end
				5: add(asbn_pkg::CHAR_COLON, 1'b0);
				6: add(asbn_pkg::CHAR_RBRACE, 1'b0);
				7: begin
					add(asbn_pkg::CHAR_SLASH, 1'b0);
					add(word_char(), 1'b0);
				end
				8: add(asbn_pkg::BYTE_NUL, 1'b0);
				default: add(asbn_pkg::CHAR_HASH, 1'b0);
			endcase
		end
		case ($urandom_range(0, 3))
			0: begin
				add(asbn_pkg::CHAR_SEMI, 1'b0);
				add_comment_text();
			end
			1: begin
				add(asbn_pkg::CHAR_SLASH, 1'b0);
				add(asbn_pkg::CHAR_SLASH, 1'b0);
				add_comment_text();
			end
			default: ;
		endcase
		add_eol();
	endtask

	task automatic add_file();
		if ($urandom_range(0, 2) == 0) begin
			add(asbn_pkg::CHAR_HASH, 1'b0);
			add_comment_text();
			add_eol();
		end
		repeat ($urandom_range(1, 4)) add_line();
		case ($urandom_range(0, 3))
			0: add(asbn_pkg::CHAR_SLASH, 1'b0);
			1: add(word_char(), 1'b0);
			default: ;
		endcase
		add(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 7) == 0)
				add(8'($urandom_range(0, 255)), 1'b1);
			else
				add(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL assembler_source_byte_normalizer_top");
		$finish;
	end

	initial begin
		int idx;
		int burst;
		int gap;

		// directed: hash header, CRLF, blanks, NUL, statement and block ends, slashes
		add(asbn_pkg::CHAR_HASH, 1'b0);
		add("x", 1'b0);
		add(asbn_pkg::BYTE_CR, 1'b0);
		add(asbn_pkg::BYTE_LF, 1'b0);
		add("A", 1'b0);
		add(asbn_pkg::BYTE_TAB, 1'b0);
		add(asbn_pkg::BYTE_SPACE, 1'b0);
		add(asbn_pkg::BYTE_NUL, 1'b0);
		add(asbn_pkg::CHAR_COLON, 1'b0);
		add(asbn_pkg::CHAR_RBRACE, 1'b0);
		add(asbn_pkg::CHAR_SLASH, 1'b0);
		add(asbn_pkg::CHAR_SLASH, 1'b0);
		add(8'hff, 1'b0);
		add(asbn_pkg::BYTE_LF, 1'b0);
		add(asbn_pkg::CHAR_SLASH, 1'b0);
		add(asbn_pkg::BYTE_CR, 1'b0);
		add(asbn_pkg::BYTE_CR, 1'b0);
		add(8'hff, 1'b0);
		add(asbn_pkg::CHAR_SEMI, 1'b0);
		add(8'h00, 1'b1);
		add(8'hff, 1'b1);
		add("q", 1'b0);
		add(asbn_pkg::CHAR_HASH, 1'b0);
		add(asbn_pkg::CHAR_SLASH, 1'b0);
		add(8'haa, 1'b1);

		while (source_text.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				add_noise();
			else
				add_file();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < source_text.size()) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			while (burst > 0 && idx < source_text.size()) begin
				push <= 1'b1;
				src_byte <= source_text[idx].b;
				is_end <= source_text[idx].e;
				@(posedge clk);
				while (full)
					@(posedge clk);
				idx++;
				burst--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		push <= 1'b0;
		@(posedge clk);

		while (waiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0 && waiting == 0)
			$display("PASS assembler_source_byte_normalizer_top");
		else
			$display("FAIL assembler_source_byte_normalizer_top");
		$finish;
	end

endmodule

`default_nettype wire
